// File: rtl/core/rgb_led_pwm_slot_encoder_macros.svh
// Assertion macros shared by the slot encoder RTL.
// Expects clk and rst_n to be in scope at each use.
`ifndef RGB_LED_PWM_SLOT_ENCODER_MACROS_SVH
`define RGB_LED_PWM_SLOT_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RLPSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLPSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rlpse_pkg.sv
// Shared types, constants and helpers for the RGB LED PWM slot encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlpse_pkg;

    localparam int ChanW   = 8;
    localparam int CmpW    = 8;
    localparam int RepW    = 10;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 10;
    localparam int IdxW    = 5;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_ZERO_CMP   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ONE_CMP    = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_RESET_CNT  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [ChanW-1:0] BRIGHTNESS_RST = 8'd255;
    localparam logic [CmpW-1:0]  ZERO_CMP_RST   = 8'd7;
    localparam logic [CmpW-1:0]  ONE_CMP_RST    = 8'd16;
    localparam logic [RepW-1:0]  RESET_CNT_RST  = 10'd240;

    // Slot positions within one pixel: leading run, 24 data bits, trailing run.
    localparam logic [IdxW-1:0] IDX_LEAD       = 5'd0;
    localparam logic [IdxW-1:0] IDX_FIRST_BIT  = 5'd1;
    localparam logic [IdxW-1:0] IDX_LAST_BIT   = 5'd24;
    localparam logic [IdxW-1:0] IDX_TRAIL      = 5'd25;

    localparam logic [2*ChanW-1:0] ROUND_BIAS = 16'd127;
    localparam logic [CmpW-1:0]    LOW_CMP    = 8'd0;

    // One scaled pixel plus its frame run flags.
    typedef struct packed {
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] blue;
        logic             lead;
        logic             trail;
    } cmd_t;

    // Divide a 16-bit value below 65280 by 255: x>>8 is low by at most one.
    function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] x);
        logic [ChanW-1:0] q1;
        logic [ChanW:0]   r;
        q1 = x[2*ChanW-1:ChanW];
        r  = {1'b0, x[ChanW-1:0]} + {1'b0, q1};
        if (r >= 9'd255)
            div255 = q1 + 8'd1;
        else
            div255 = q1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rgb_led_pwm_slot_encoder.sv
// Top level of the RGB LED PWM slot encoder: config registers, front, queue, back.
// Depends on rlpse_pkg, rlpse_front, rlpse_fifo and rlpse_back.
//
//   Channel   Handshake               Payload
//   pixel in  push / full             red, green, blue, last_pixel
//   slot out  empty / pop             compare_value, repeat_count, last
//   config    cfg_we (no stall)       cfg_index, cfg_data
//
// One slot transaction leaves per cycle while the receiver keeps popping, and a pixel
// gives 24 to 26 of them; the back end's slot sequencer sets that figure.
// An accepted pixel is registered in the scaling stage (multiply, then divide by 255
// on the way in) and enters the queue when it has room; the back end's command and output registers follow.
// full rises only when the queue of FIFO_DEPTH commands and the scaling stage are taken.
// Reset clears all control state; the next pixel opens a frame.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_pwm_slot_encoder #(
    parameter int FIFO_DEPTH = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [rlpse_pkg::ChanW-1:0]   red,
    input  wire logic [rlpse_pkg::ChanW-1:0]   green,
    input  wire logic [rlpse_pkg::ChanW-1:0]   blue,
    input  wire logic                          last_pixel,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [rlpse_pkg::CmpW-1:0]         compare_value,
    output logic [rlpse_pkg::RepW-1:0]         repeat_count,
    output logic                               last,
    input  wire logic                          cfg_we,
    input  wire logic [rlpse_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [rlpse_pkg::CfgW-1:0]    cfg_data
);
    import rlpse_pkg::*;

    logic [ChanW-1:0] brightness_reg;
    logic [CmpW-1:0]  zero_cmp_reg;
    logic [CmpW-1:0]  one_cmp_reg;
    logic [RepW-1:0]  reset_cnt_reg;

    logic cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t cmd_wdata, cmd_rdata;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHTNESS_RST;
            zero_cmp_reg   <= ZERO_CMP_RST;
            one_cmp_reg    <= ONE_CMP_RST;
            reset_cnt_reg  <= RESET_CNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BRIGHTNESS: brightness_reg <= cfg_data[ChanW-1:0];
                REG_ZERO_CMP:   zero_cmp_reg   <= cfg_data[CmpW-1:0];
                REG_ONE_CMP:    one_cmp_reg    <= cfg_data[CmpW-1:0];
                REG_RESET_CNT:  reset_cnt_reg  <= cfg_data[RepW-1:0];
                default:        ;
            endcase
        end
    end

    rlpse_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .last_pixel       (last_pixel),
        .brightness       (brightness_reg),
        .reset_slot_count (reset_cnt_reg),
        .cmd_push         (cmd_push),
        .cmd_data         (cmd_wdata),
        .cmd_full         (cmd_full)
    );

    rlpse_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    rlpse_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_data          (cmd_rdata),
        .cmd_empty         (cmd_empty),
        .cmd_pop           (cmd_pop),
        .zero_high_compare (zero_cmp_reg),
        .one_high_compare  (one_cmp_reg),
        .reset_slot_count  (reset_cnt_reg),
        .empty             (empty),
        .pop               (pop),
        .compare_value     (compare_value),
        .repeat_count      (repeat_count),
        .last              (last)
    );

endmodule

`default_nettype wire

// File: rtl/core/rlpse_front.sv
// Front end: accepts pixels, scales channels by brightness, tags frame runs.
// Depends on rlpse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpse_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [rlpse_pkg::ChanW-1:0] red,
    input  wire logic [rlpse_pkg::ChanW-1:0] green,
    input  wire logic [rlpse_pkg::ChanW-1:0] blue,
    input  wire logic                      last_pixel,
    input  wire logic [rlpse_pkg::ChanW-1:0] brightness,
    input  wire logic [rlpse_pkg::RepW-1:0]  reset_slot_count,
    output logic                           cmd_push,
    output rlpse_pkg::cmd_t                cmd_data,
    input  wire logic                      cmd_full
);
    import rlpse_pkg::*;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 frame_start_reg, frame_start_next;
    logic [2*ChanW-1:0]   prod_g_reg, prod_r_reg, prod_b_reg;
    logic                 lead_reg, trail_reg;
    logic                 s1_ready;
    logic                 accept;
    logic                 rst_nz;

    // Stage advances when empty or when the queue takes its contents
    assign s1_ready = !s1_valid_reg || !cmd_full;
    assign full     = !s1_ready;
    assign accept   = push && s1_ready;
    assign rst_nz   = (reset_slot_count != '0);

    // Track frame start and stage valid
    always_comb
    begin
        frame_start_next = frame_start_reg;
        s1_valid_next    = s1_valid_reg;
        if (accept)
        begin
            frame_start_next = last_pixel;
            s1_valid_next    = 1'b1;
        end
        else if (!cmd_full)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            frame_start_reg <= 1'b1;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            frame_start_reg <= frame_start_next;
        end
    end

    // Register products with rounding bias and run flags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_g_reg <= {{ChanW{1'b0}}, green} * {{ChanW{1'b0}}, brightness} + ROUND_BIAS;
            prod_r_reg <= {{ChanW{1'b0}}, red} * {{ChanW{1'b0}}, brightness} + ROUND_BIAS;
            prod_b_reg <= {{ChanW{1'b0}}, blue} * {{ChanW{1'b0}}, brightness} + ROUND_BIAS;
            lead_reg   <= frame_start_reg && rst_nz;
            trail_reg  <= last_pixel && rst_nz;
        end
    end

    // Finish the divide by 255 on the way into the queue
    assign cmd_push       = s1_valid_reg && !cmd_full;
    assign cmd_data.green = div255(prod_g_reg);
    assign cmd_data.red   = div255(prod_r_reg);
    assign cmd_data.blue  = div255(prod_b_reg);
    assign cmd_data.lead  = lead_reg;
    assign cmd_data.trail = trail_reg;

endmodule

`default_nettype wire

// File: rtl/core/rlpse_fifo.sv
// Short command queue between front and back end.
// Depends on rlpse_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_led_pwm_slot_encoder_macros.svh"

module rlpse_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rlpse_pkg::cmd_t wdata,
    output logic                 full,
    input  wire logic            pop,
    output rlpse_pkg::cmd_t      rdata,
    output logic                 empty
);
    import rlpse_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PTR_MAX = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CNT_MAX = CntW'(DEPTH);

    cmd_t            mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CNT_MAX);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    `RLPSE_ASSERT_IMP(a_fifo_count_bound, 1'b1, count_reg <= CNT_MAX, "queue count overflow")
    `RLPSE_ASSERT_NXT(a_fifo_fill_step, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not grow on push")

endmodule

`default_nettype wire

// File: rtl/core/rlpse_back.sv
// Back end: expands one command into PWM slot transactions, one per cycle while the receiver pops.
// Depends on rlpse_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_led_pwm_slot_encoder_macros.svh"

module rlpse_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rlpse_pkg::cmd_t             cmd_data,
    input  wire logic                        cmd_empty,
    output logic                             cmd_pop,
    input  wire logic [rlpse_pkg::CmpW-1:0]  zero_high_compare,
    input  wire logic [rlpse_pkg::CmpW-1:0]  one_high_compare,
    input  wire logic [rlpse_pkg::RepW-1:0]  reset_slot_count,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [rlpse_pkg::CmpW-1:0]       compare_value,
    output logic [rlpse_pkg::RepW-1:0]       repeat_count,
    output logic                             last
);
    import rlpse_pkg::*;

    cmd_t            cmd_reg;
    logic            busy_reg, busy_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [CmpW-1:0] cmp_reg;
    logic [RepW-1:0] rep_reg;
    logic            last_reg;

    logic            adv;
    logic [IdxW-1:0] end_idx;
    logic            at_end;
    logic            load;
    logic [3*ChanW-1:0] bits;
    logic [IdxW-1:0] bit_pos;
    logic            is_run;
    logic [CmpW-1:0] slot_cmp;
    logic [RepW-1:0] slot_rep;

    // Output register moves when empty or taken
    assign adv     = !out_valid_reg || pop;
    assign end_idx = cmd_reg.trail ? IDX_TRAIL : IDX_LAST_BIT;
    assign at_end  = (idx_reg == end_idx);
    assign load    = !cmd_empty && (!busy_reg || (adv && at_end));
    assign cmd_pop = load;

    // Pick the slot for the current position, green first, MSB first
    assign bits    = {cmd_reg.green, cmd_reg.red, cmd_reg.blue};
    assign bit_pos = IDX_LAST_BIT - idx_reg;
    assign is_run  = (idx_reg == IDX_LEAD) || (idx_reg == IDX_TRAIL);

    always_comb
    begin
        if (is_run)
        begin
            slot_cmp = LOW_CMP;
            slot_rep = reset_slot_count;
        end
        else
        begin
            slot_cmp = bits[bit_pos] ? one_high_compare : zero_high_compare;
            slot_rep = RepW'(1);
        end
    end

    // Sequence positions across the command
    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = busy_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = cmd_data.lead ? IDX_LEAD : IDX_FIRST_BIT;
        end
        else if (busy_reg && adv)
        begin
            if (at_end)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= IDX_FIRST_BIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold command and output payload
    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= cmd_data;
        if (adv && busy_reg)
        begin
            cmp_reg  <= slot_cmp;
            rep_reg  <= slot_rep;
            last_reg <= at_end;
        end
    end

    assign empty         = !out_valid_reg;
    assign compare_value = cmp_reg;
    assign repeat_count  = rep_reg;
    assign last          = last_reg;

    `RLPSE_ASSERT_IMP(a_idx_range, busy_reg, idx_reg <= IDX_TRAIL, "slot position out of range")
    `RLPSE_ASSERT_IMP(a_no_lead_skip, busy_reg && !cmd_reg.lead, idx_reg != IDX_LEAD,
        "leading run without lead flag")
    `RLPSE_ASSERT_IMP(a_run_is_low, out_valid_reg && (rep_reg != RepW'(1)), cmp_reg == LOW_CMP,
        "multi-slot run with nonzero compare")
    `RLPSE_ASSERT_NXT(a_pop_on_load, load, busy_reg, "command loaded but back end idle")

endmodule

`default_nettype wire

// File: tb/tb_rgb_led_pwm_slot_encoder.sv
// Self-checking testbench for rgb_led_pwm_slot_encoder: queue-style pixel and slot ports.
// Depends on rlpse_pkg and the encoder RTL; the slot predictor is kept here.
`timescale 1ns / 1ps

module tb_rgb_led_pwm_slot_encoder;

    import rlpse_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic             last_pixel;
    } pixel_t;

    typedef struct {
        logic [CmpW-1:0] cmp;
        logic [RepW-1:0] rep;
        logic            last;
    } slot_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [ChanW-1:0] red = '0;
    logic [ChanW-1:0] green = '0;
    logic [ChanW-1:0] blue = '0;
    logic last_pixel = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [CmpW-1:0] compare_value;
    logic [RepW-1:0] repeat_count;
    logic last;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgW-1:0] cfg_data = '0;

    // Shadow of the block's registers and frame state
    logic [ChanW-1:0] shadow_brightness = BRIGHTNESS_RST;
    logic [CmpW-1:0]  shadow_zero_cmp = ZERO_CMP_RST;
    logic [CmpW-1:0]  shadow_one_cmp = ONE_CMP_RST;
    logic [RepW-1:0]  shadow_reset_cnt = RESET_CNT_RST;
    logic             frame_open_next = 1'b1;

    pixel_t pixels_to_send[$];
    slot_t  expected_slots[$];

    int  errors = 0;
    int  cycles = 0;
    int  pixels_sent = 0;
    int  frames_sent = 0;
    int  slots_checked = 0;
    int  settings_used = 1;
    int  send_gap = 0;
    int  pop_wait = 0;
    bit  steady = 1'b0;
    bit  hold_on = 1'b0;
    pixel_t cur_pixel;

    rgb_led_pwm_slot_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .last_pixel    (last_pixel),
        .empty         (empty),
        .pop           (pop),
        .compare_value (compare_value),
        .repeat_count  (repeat_count),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Brightness scaling with rounding: (c*b+127)/255
    function automatic logic [ChanW-1:0] scale_chan(logic [ChanW-1:0] c);
        int prod;
        prod = int'(c) * int'(shadow_brightness) + 127;
        return ChanW'(prod / 255);
    endfunction

    // Expand one accepted pixel into its slot transactions
    function automatic void encode_pixel(pixel_t px);
        logic [3*ChanW-1:0] bits;
        slot_t s;
        bits = {scale_chan(px.green), scale_chan(px.red), scale_chan(px.blue)};
        s.last = 1'b0;
        if (frame_open_next && shadow_reset_cnt != 0)
        begin
            s.cmp = LOW_CMP;
            s.rep = shadow_reset_cnt;
            expected_slots.push_back(s);
        end
        for (int i = 3 * ChanW - 1; i >= 0; i--)
        begin
            s.cmp = bits[i] ? shadow_one_cmp : shadow_zero_cmp;
            s.rep = RepW'(1);
            expected_slots.push_back(s);
        end
        if (px.last_pixel && shadow_reset_cnt != 0)
        begin
            s.cmp = LOW_CMP;
            s.rep = shadow_reset_cnt;
            expected_slots.push_back(s);
        end
        expected_slots[expected_slots.size() - 1].last = 1'b1;
        frame_open_next = px.last_pixel;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR slot %0d: %s got %0d expected %0d", slots_checked, what, got, want);
        errors++;
    endtask

    // Pixel driver: offer queued pixels with a random gap after each transaction unless steady
    always @(posedge clk)
    begin : pixel_driver
        bit nxt_push;
        if (rst_n)
        begin
            nxt_push = push;
            if (push && !full)
            begin
                encode_pixel(cur_pixel);
                pixels_sent++;
                if (cur_pixel.last_pixel)
                    frames_sent++;
                nxt_push = 1'b0;
                send_gap = steady ? 0 : $urandom_range(0, 5);
            end
            if (!nxt_push)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (pixels_to_send.size() != 0)
                begin
                    cur_pixel = pixels_to_send.pop_front();
                    red <= cur_pixel.red;
                    green <= cur_pixel.green;
                    blue <= cur_pixel.blue;
                    last_pixel <= cur_pixel.last_pixel;
                    nxt_push = 1'b1;
                end
            end
            push <= nxt_push;
        end
    end

    // Slot monitor: check each popped transaction, stall at random unless steady
    always @(posedge clk)
    begin : slot_monitor
        bit nxt_pop;
        slot_t want;
        if (rst_n)
        begin
            nxt_pop = pop;
            if (pop && !empty)
            begin
                if (expected_slots.size() == 0)
                    report_mismatch("unexpected slot, compare_value", compare_value, -1);
                else
                begin
                    want = expected_slots.pop_front();
                    if (compare_value !== want.cmp)
                        report_mismatch("compare_value", compare_value, want.cmp);
                    if (repeat_count !== want.rep)
                        report_mismatch("repeat_count", repeat_count, want.rep);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
                slots_checked++;
                nxt_pop = 1'b0;
                pop_wait = steady ? 0 : $urandom_range(0, 5);
            end
            if (!nxt_pop && !hold_on)
            begin
                if (pop_wait != 0)
                    pop_wait--;
                else
                    nxt_pop = 1'b1;
            end
            pop <= nxt_pop;
        end
    end

    // Long receiver hold-off so the encoder fills and raises full
    initial
    begin
        wait (pixels_sent >= 80);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d slots still expected",
                     cycles, expected_slots.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_BRIGHTNESS: shadow_brightness = data[ChanW-1:0];
            REG_ZERO_CMP:   shadow_zero_cmp = data[CmpW-1:0];
            REG_ONE_CMP:    shadow_one_cmp = data[CmpW-1:0];
            REG_RESET_CNT:  shadow_reset_cnt = data[RepW-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Write all registers; the unused top bits of the 8-bit registers get junk
    task automatic set_config(logic [7:0] br, logic [7:0] zc, logic [7:0] oc,
                              logic [9:0] rc);
        write_reg(REG_BRIGHTNESS, {2'($urandom_range(0, 3)), br});
        write_reg(REG_ZERO_CMP, {2'($urandom_range(0, 3)), zc});
        write_reg(REG_ONE_CMP, {2'($urandom_range(0, 3)), oc});
        write_reg(REG_RESET_CNT, rc);
        settings_used++;
    endtask

    task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic lp);
        pixel_t px;
        px.red = r;
        px.green = g;
        px.blue = b;
        px.last_pixel = lp;
        pixels_to_send.push_back(px);
    endtask

    // Hold until every queued pixel went out and every slot came back
    task automatic drain();
        while (pixels_to_send.size() != 0 || push || expected_slots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly whole frames with random content, some stray pixels with a random mark
    task automatic queue_random_pixels(int n);
        int left;
        int flen;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom_range(0, 1)));
                left--;
            end
            else
            begin
                flen = $urandom_range(1, 6);
                for (int i = 0; i < flen; i++)
                    add_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == flen - 1);
                left -= flen;
            end
        end
    endtask

    function automatic logic [9:0] pick_reset_cnt();
        case ($urandom_range(0, 4))
            0: return 10'd0;
            1: return 10'd1;
            2: return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: frame open, all-zero and all-one pixels, single-pixel frame
        add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pixel(8'h80, 8'h01, 8'h55, 1'b1);
        add_pixel(8'hAA, 8'h7F, 8'hFE, 1'b1);
        add_pixel(8'h01, 8'hC3, 8'h3C, 1'b0);
        drain();

        // Zero brightness, compare extremes, no reset runs
        set_config(8'd0, 8'd0, 8'd255, 10'd0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pixel(8'h12, 8'h34, 8'h56, 1'b1);
        add_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
        add_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        drain();

        // Half brightness, swapped compares, longest reset run
        set_config(8'd128, 8'd255, 8'd0, 10'd1023);
        add_pixel(8'hFF, 8'h01, 8'h02, 1'b1);
        add_pixel(8'h7F, 8'h80, 8'h81, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        drain();

        // Lowest nonzero brightness and shortest reset run
        set_config(8'd1, 8'd3, 8'd200, 10'd1);
        add_pixel(8'hFF, 8'h80, 8'h7F, 1'b0);
        add_pixel(8'h81, 8'hFE, 8'h01, 1'b1);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        add_pixel(8'h40, 8'h20, 8'h10, 1'b0);
        drain();

        // Random phases, alternating gappy and back-to-back traffic
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 4)
                set_config(8'd255, 8'd255, 8'd255, 10'd1023);
            else
                set_config(pick_byte(), pick_byte(), pick_byte(), pick_reset_cnt());
            @(posedge clk);
            steady <= (ph % 2 == 1);
            queue_random_pixels(100);
            drain();
        end

        $display("Covered %0d pixels in %0d frames over %0d register settings,",
                 pixels_sent, frames_sent, settings_used);
        $display("with %0d slot transactions checked and a long output stall.",
                 slots_checked);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rlpse_pkg.sv
rtl/core/rlpse_front.sv
rtl/core/rlpse_fifo.sv
rtl/core/rlpse_back.sv
rtl/core/rgb_led_pwm_slot_encoder.sv
tb/tb_rgb_led_pwm_slot_encoder.sv
